// ===== hw/rtl/adtw_pkg.sv =====
// shared types, constants and helpers for the two-wire adc serial master
package adtw_pkg;

    // widths of the fixed fields
    localparam int TICK_W      = 16;
    localparam int SETTLE_W    = 4;
    localparam int CLK_CNT_W   = 6;
    localparam int RESULT_W    = 24;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 32;

    // default sample length
    localparam int SAMPLE_BITS_DEF = 24;

    // register reset values
    localparam logic [TICK_W-1:0]   HALF_PERIOD_RST = 16'd100;
    localparam logic [TICK_W-1:0]   TIMEOUT_RST     = 16'd1000;
    localparam logic [SETTLE_W-1:0] SETTLE_RST      = 4'd5;

    // write transaction framing
    localparam logic [6:0]           CMD_WRITE    = 7'h65;
    localparam logic [CLK_CNT_W-1:0] FLAG_CLOCK   = 6'd25;
    localparam logic [CLK_CNT_W-1:0] CMD_FIRST    = 6'd30;
    localparam logic [CLK_CNT_W-1:0] TURN_CLOCK   = 6'd37;
    localparam logic [CLK_CNT_W-1:0] CFG_LAST     = 6'd45;
    localparam logic [CLK_CNT_W-1:0] WRITE_CLOCKS = 6'd46;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE      = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TMO_HIGH  = 2'd1;
    localparam logic [1:0] ST_TMO_LOW   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_HIGH,
        PH_WAIT_LOW,
        PH_SETTLE,
        PH_CLK_HI,
        PH_CLK_LO
    } t_phase;

    // configuration register set
    typedef struct packed {
        logic [TICK_W-1:0]   half_period_ticks;
        logic [TICK_W-1:0]   timeout_limit;
        logic [SETTLE_W-1:0] settle_units;
    } t_cfg;

    // control state of the link sequencer
    typedef struct packed {
        t_phase                phase;
        logic [CLK_CNT_W-1:0]  clock_count;
        logic [TICK_W-1:0]     tick_count;
        logic [TICK_W-1:0]     wait_count;
        logic [7:0]            shift_out;
        logic                  kind_latched;
        logic                  flag_reg;
        logic [RESULT_W-1:0]   last_sample;
        logic [1:0]            last_status;
    } t_state;

    // line levels and flags shown with each beat
    typedef struct packed {
        logic scl;
        logic sda_out;
        logic sda_drive;
        logic busy;
        logic done;
    } t_line;

    // level driven on the data line for a given write clock
    function automatic logic drive_level(input logic [CLK_CNT_W-1:0] c,
                                         input logic [7:0] cfg_byte);
        logic [CLK_CNT_W-1:0] cmd_pos;
        logic [CLK_CNT_W-1:0] cfg_pos;
        logic                 lvl;
        cmd_pos = (TURN_CLOCK - 6'd1) - c;
        cfg_pos = CFG_LAST - c;
        if (c < CMD_FIRST) begin
            lvl = 1'b0;
        end else if (c < TURN_CLOCK) begin
            lvl = CMD_WRITE[cmd_pos[2:0]];
        end else if (c == TURN_CLOCK) begin
            lvl = CMD_WRITE[0];
        end else if (c <= CFG_LAST) begin
            lvl = cfg_byte[cfg_pos[2:0]];
        end else begin
            lvl = cfg_byte[0];
        end
        return lvl;
    endfunction

endpackage

// ===== hw/rtl/adtw_cfg_regs.sv =====
// configuration register file of the two-wire adc serial master
module adtw_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [adtw_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [adtw_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output adtw_pkg::t_cfg                  o_cfg
);
    import adtw_pkg::*;

    t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_PERIOD_RST;
            r_cfg.timeout_limit     <= TIMEOUT_RST;
            r_cfg.settle_units      <= SETTLE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_HALF_PERIOD) begin
                r_cfg.half_period_ticks <= i_cfg_wdata[TICK_W-1:0];
            end
            if (i_cfg_addr == REG_TIMEOUT) begin
                r_cfg.timeout_limit <= i_cfg_wdata[TICK_W-1:0];
            end
            if (i_cfg_addr == REG_SETTLE) begin
                r_cfg.settle_units <= i_cfg_wdata[SETTLE_W-1:0];
            end
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/adtw_step.sv =====
// next-state logic of the link sequencer for one timing tick
module adtw_step #(
    parameter int SAMPLE_BITS = adtw_pkg::SAMPLE_BITS_DEF
) (
    input  adtw_pkg::t_cfg         i_cfg,
    input  adtw_pkg::t_state       i_st,
    input  logic [SAMPLE_BITS-1:0] i_shift,
    input  logic                   i_start_req,
    input  logic                   i_req_type,
    input  logic [7:0]             i_config_byte,
    input  logic                   i_sda_in,
    output adtw_pkg::t_state       o_st,
    output logic [SAMPLE_BITS-1:0] o_shift,
    output adtw_pkg::t_line        o_line
);
    import adtw_pkg::*;

    localparam logic [CLK_CNT_W-1:0] READ_CLOCKS = CLK_CNT_W'(SAMPLE_BITS);

    t_state                n_st;
    logic [SAMPLE_BITS-1:0] n_shift;
    logic                  done;
    logic [TICK_W-1:0]     hp;
    logic [TICK_W:0]       tick_inc;
    logic                  unit_end;
    logic [TICK_W:0]       wait_inc;
    logic [TICK_W-1:0]     wait_dec;
    logic [TICK_W-1:0]     settle_val;
    logic [CLK_CNT_W-1:0]  total;
    logic [31:0]           shift_ext;
    logic                  drv;

    // delay unit counter and sequencer
    always_comb begin
        n_st       = i_st;
        n_shift    = i_shift;
        done       = 1'b0;
        hp         = (i_cfg.half_period_ticks == '0) ? TICK_W'(1) : i_cfg.half_period_ticks;
        tick_inc   = {1'b0, i_st.tick_count} + 17'd1;
        unit_end   = (tick_inc >= {1'b0, hp});
        wait_inc   = {1'b0, i_st.wait_count} + 17'd1;
        wait_dec   = (i_st.wait_count != '0) ? (i_st.wait_count - 16'd1) : i_st.wait_count;
        settle_val = i_st.kind_latched ? TICK_W'(1) : TICK_W'(i_cfg.settle_units);
        total      = i_st.kind_latched ? WRITE_CLOCKS : READ_CLOCKS;
        shift_ext  = '0;

        unique case (i_st.phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_st.kind_latched = i_req_type;
                    n_st.shift_out    = i_config_byte;
                    n_st.phase        = PH_WAIT_HIGH;
                    n_st.tick_count   = '0;
                    n_st.wait_count   = '0;
                    n_st.clock_count  = '0;
                end
            end
            PH_WAIT_HIGH, PH_WAIT_LOW: begin
                if (unit_end) begin
                    n_st.tick_count = '0;
                    n_st.wait_count = wait_inc[TICK_W-1:0];
                    if (wait_inc > {1'b0, i_cfg.timeout_limit}) begin
                        n_st.phase       = PH_IDLE;
                        n_st.last_status = (i_st.phase == PH_WAIT_HIGH) ? ST_TMO_HIGH
                                                                        : ST_TMO_LOW;
                        n_st.wait_count  = '0;
                        n_st.clock_count = '0;
                        done             = 1'b1;
                    end else if (i_st.phase == PH_WAIT_HIGH && i_sda_in) begin
                        n_st.phase      = PH_WAIT_LOW;
                        n_st.wait_count = '0;
                    end else if (i_st.phase == PH_WAIT_LOW && !i_sda_in) begin
                        // data ready: settle, or clock at once when settle is zero
                        n_st.wait_count = settle_val;
                        if (settle_val == '0) begin
                            n_st.phase       = PH_CLK_HI;
                            n_st.clock_count = CLK_CNT_W'(1);
                            n_shift          = '0;
                        end else begin
                            n_st.phase = PH_SETTLE;
                        end
                    end
                end else begin
                    n_st.tick_count = tick_inc[TICK_W-1:0];
                end
            end
            PH_SETTLE: begin
                if (unit_end) begin
                    n_st.tick_count = '0;
                    n_st.wait_count = wait_dec;
                    if (wait_dec == '0) begin
                        n_st.phase       = PH_CLK_HI;
                        n_st.clock_count = CLK_CNT_W'(1);
                        n_shift          = '0;
                    end
                end else begin
                    n_st.tick_count = tick_inc[TICK_W-1:0];
                end
            end
            PH_CLK_HI: begin
                if (unit_end) begin
                    n_st.tick_count = '0;
                    n_st.phase      = PH_CLK_LO;
                end else begin
                    n_st.tick_count = tick_inc[TICK_W-1:0];
                end
            end
            PH_CLK_LO: begin
                if (unit_end) begin
                    n_st.tick_count = '0;
                    // sample the line at the end of the low half
                    if (!i_st.kind_latched) begin
                        n_shift = {i_shift[SAMPLE_BITS-2:0], i_sda_in};
                    end else if (i_st.clock_count == FLAG_CLOCK) begin
                        n_st.flag_reg = i_sda_in;
                    end
                    shift_ext = 32'(n_shift);
                    if (i_st.clock_count >= total) begin
                        if (!i_st.kind_latched) begin
                            n_st.last_sample = shift_ext[RESULT_W-1:0];
                        end
                        n_st.phase       = PH_IDLE;
                        n_st.last_status = ST_OK;
                        n_st.wait_count  = '0;
                        n_st.clock_count = '0;
                        done             = 1'b1;
                    end else begin
                        n_st.clock_count = i_st.clock_count + 6'd1;
                        n_st.phase       = PH_CLK_HI;
                    end
                end else begin
                    n_st.tick_count = tick_inc[TICK_W-1:0];
                end
            end
            default: begin
                n_st.phase       = PH_IDLE;
                n_st.last_status = ST_OK;
                n_st.tick_count  = '0;
                n_st.wait_count  = '0;
                n_st.clock_count = '0;
            end
        endcase
    end

    // line levels from the state after this tick
    always_comb begin
        drv = n_st.kind_latched
              && (n_st.phase == PH_CLK_HI || n_st.phase == PH_CLK_LO)
              && (n_st.clock_count >= CMD_FIRST);
        o_line.scl       = (n_st.phase == PH_CLK_HI);
        o_line.sda_out   = drv ? drive_level(n_st.clock_count, n_st.shift_out) : 1'b0;
        o_line.sda_drive = drv;
        o_line.busy      = (n_st.phase != PH_IDLE);
        o_line.done      = done;
    end

    assign o_st    = n_st;
    assign o_shift = n_shift;

endmodule

// ===== hw/rtl/adc_two_wire_serial_master_unit.sv =====
// top level of the two-wire adc serial master
//
// Each input beat is one timing tick of the serial link: it carries the
// sampled data line, a start request, the request kind (read or write, on
// s_axis_tuser) and the configuration byte for a write. Every input beat
// gives exactly one output beat with the clock and data line levels, the
// drive enable, busy and done flags, the last sample, the write flag and
// the status of the last transaction.
// The sequencer state steps once per accepted beat and the output beat is
// registered; one beat is taken every cycle unless the receiver stalls.
// The rate is set by the single result register: a new beat enters while
// the previous result is taken in the same cycle.
// When the receiver stalls with a result held, s_axis_tready drops and the
// sequencer does not advance until that result is taken.
// Reset returns the sequencer to idle, clears counters, sample, flag and
// status, and loads the register defaults (100 ticks per half period,
// timeout 1000 units, settle 5 units). The user must write registers
// through the plain write port only while the link is idle; not enforced.
module adc_two_wire_serial_master_unit #(
    parameter int SAMPLE_BITS = adtw_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // register write port
    input  logic                            i_cfg_we,
    input  logic [adtw_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [adtw_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // tick input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // start_req[0], config_byte[8:1], sda_in[9], zero fill [15:10]
    input  logic [adtw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                            s_axis_tuser,
    // result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
    // sample[28:5], write_flag[29], status[31:30]
    output logic [adtw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import adtw_pkg::*;

    t_cfg                   cfg;
    t_state                 r_st;
    t_state                 n_st;
    logic [SAMPLE_BITS-1:0] r_shift;
    logic [SAMPLE_BITS-1:0] n_shift;
    t_line                  line;
    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic                   in_beat;

    adtw_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    adtw_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .i_cfg         (cfg),
        .i_st          (r_st),
        .i_shift       (r_shift),
        .i_start_req   (s_axis_tdata[0]),
        .i_req_type    (s_axis_tuser),
        .i_config_byte (s_axis_tdata[8:1]),
        .i_sda_in      (s_axis_tdata[9]),
        .o_st          (n_st),
        .o_shift       (n_shift),
        .o_line        (line)
    );

    // take a beat whenever the result register is free or being emptied
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase        <= PH_IDLE;
            r_st.clock_count  <= '0;
            r_st.tick_count   <= '0;
            r_st.wait_count   <= '0;
            r_st.shift_out    <= '0;
            r_st.kind_latched <= 1'b0;
            r_st.flag_reg     <= 1'b0;
            r_st.last_sample  <= '0;
            r_st.last_status  <= ST_OK;
            r_shift           <= '0;
        end else if (in_beat) begin
            r_st    <= n_st;
            r_shift <= n_shift;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_data <= {n_st.last_status, n_st.flag_reg, n_st.last_sample,
                           line.done, line.busy, line.sda_drive, line.sda_out, line.scl};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
